// ===== hdl/stgwp_pkg.sv =====
// Shared constants, types and the quarter-wave sine function for the tone generator.
package stgwp_pkg;

    localparam int PHASE_BITS_DEF     = 32;
    localparam int SINE_ADDR_BITS_DEF = 10;
    localparam int FRAME_BITS_DEF     = 16;

    localparam int FIELD_FRAME_W = 16;
    localparam int SAMPLE_W      = 16;
    localparam int MAG_W         = 15;
    localparam int VOLUME_W      = 15;
    localparam int PAN_W         = 8;
    localparam int GAIN_W        = 8;
    localparam int PROD_W        = MAG_W + GAIN_W;
    localparam int STEP_W        = 32;
    localparam int CFG_DATA_W    = 32;
    localparam int CFG_INDEX_W   = 3;

    // Register indexes on the configuration port
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ENABLE       = 3'd0,
        REG_LATENCY_MODE = 3'd1,
        REG_TARGET       = 3'd2,
        REG_MAX          = 3'd3,
        REG_VOLUME       = 3'd4,
        REG_PAN          = 3'd5,
        REG_PHASE_STEP   = 3'd6
    } cfg_reg_t;

    localparam logic                     ENABLE_RST  = 1'b0;
    localparam logic                     LATENCY_RST = 1'b1;
    localparam logic [FIELD_FRAME_W-1:0] TARGET_RST  = 16'd3200;
    localparam logic [FIELD_FRAME_W-1:0] MAX_RST     = 16'd3200;
    localparam logic [VOLUME_W-1:0]      VOLUME_RST  = 15'd6000;
    localparam logic signed [PAN_W-1:0]  PAN_RST     = 8'sd0;
    localparam logic [STEP_W-1:0]        STEP_RST    = 32'd22967740;

    localparam logic signed [PAN_W-1:0]  PAN_SPAN    = 8'sd100;
    localparam logic signed [PAN_W-1:0]  PAN_SPAN_N  = -8'sd100;

    // floor(a / 200) == (a * DIV_RECIP) >> DIV_SHIFT for every a below 2^23
    localparam int                       DIV_SHIFT   = 31;
    localparam int                       RECIP_W     = 24;
    localparam logic [RECIP_W-1:0]       DIV_RECIP   = 24'd10737419;

    localparam logic [63:0]              HALF_PI_Q30 = 64'd1686629713;

    typedef struct packed {
        logic accept;
        logic rom_load;
        logic vol_load;
        logic gain_load;
        logic out_plan;
        logic out_sample;
    } dp_cmd_t;

    // Quarter-wave sine entry in Q15, Taylor series to x^13; evaluated at elaboration only
    function automatic logic [MAG_W-1:0] quarter_sine(input int unsigned r,
                                                      input int unsigned qbits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] res;
        x    = (HALF_PI_Q30 * 64'(r)) >> qbits;
        x2   = (x * x) >> 30;
        term = x;
        pos  = x;
        neg  = 64'd0;
        term = ((term * x2) >> 30) / 64'd6;
        neg  = neg + term;
        term = ((term * x2) >> 30) / 64'd20;
        pos  = pos + term;
        term = ((term * x2) >> 30) / 64'd42;
        neg  = neg + term;
        term = ((term * x2) >> 30) / 64'd72;
        pos  = pos + term;
        term = ((term * x2) >> 30) / 64'd110;
        neg  = neg + term;
        term = ((term * x2) >> 30) / 64'd156;
        pos  = pos + term;
        res  = (pos >= neg) ? (pos - neg) : 64'd0;
        res  = (res + 64'd16384) >> 15;
        if (res > 64'd32767)
        begin
            res = 64'd32767;
        end
        return res[MAG_W-1:0];
    endfunction

endpackage

// ===== hdl/stgwp_ctrl.sv =====
// Controller state machine: request handshakes, stage sequencing, output register valid.
module stgwp_ctrl
    import stgwp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  logic    kind,
    output logic    in_stall,
    output logic    out_valid,
    input  logic    out_stall,
    output dp_cmd_t cmd
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_PLAN = 6'b000010,
        ST_ROM  = 6'b000100,
        ST_VOL  = 6'b001000,
        ST_GAIN = 6'b010000,
        ST_DIV  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = kind ? ST_ROM : ST_PLAN;
                end
            end
            ST_PLAN:
            begin
                // hold until the output register can take the result
                if (out_free)
                begin
                    cmd.out_plan = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_ROM:
            begin
                cmd.rom_load = 1'b1;
                state_next   = ST_VOL;
            end
            ST_VOL:
            begin
                cmd.vol_load = 1'b1;
                state_next   = ST_GAIN;
            end
            ST_GAIN:
            begin
                cmd.gain_load = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                if (out_free)
                begin
                    cmd.out_sample = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_plan || cmd.out_sample)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_out_rise_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_PLAN || $past(state_reg) == ST_DIV))
        else $error("result appeared without a finishing stage");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_plan || cmd.out_sample) |-> (!out_valid_reg || !out_stall))
        else $error("result register overwritten while stalled");

    a_sample_path: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && kind) |=> (state_reg == ST_ROM))
        else $error("sample request did not enter the lookup stage");

    a_plan_path: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && !kind) |=> (state_reg == ST_PLAN))
        else $error("plan request did not enter the plan stage");
`endif

endmodule

// ===== hdl/stgwp_datapath.sv =====
// Datapath: phase accumulator, sine table, volume and pan scaling, fill planner, result register.
module stgwp_datapath
    import stgwp_pkg::*;
#(
    parameter int PHASE_BITS     = PHASE_BITS_DEF,
    parameter int SINE_ADDR_BITS = SINE_ADDR_BITS_DEF,
    parameter int FRAME_BITS     = FRAME_BITS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  dp_cmd_t                    cmd,
    input  logic                       kind,
    input  logic [FIELD_FRAME_W-1:0]   free_frames,
    input  logic [FIELD_FRAME_W-1:0]   queued_frames,
    input  logic                       enable,
    input  logic                       latency_mode,
    input  logic [FIELD_FRAME_W-1:0]   target_frames,
    input  logic [FIELD_FRAME_W-1:0]   max_frames,
    input  logic [VOLUME_W-1:0]        volume,
    input  logic signed [PAN_W-1:0]    pan,
    input  logic [STEP_W-1:0]          phase_step,
    output logic [FIELD_FRAME_W-1:0]   fill_count,
    output logic signed [SAMPLE_W-1:0] left_sample,
    output logic signed [SAMPLE_W-1:0] right_sample
);

    localparam int QBITS  = SINE_ADDR_BITS - 2;
    localparam int QSIZE  = 1 << QBITS;
    localparam int RA_W   = QBITS + 1;
    localparam int FW     = (FRAME_BITS < FIELD_FRAME_W) ? FRAME_BITS : FIELD_FRAME_W;
    localparam int SW     = (PHASE_BITS > STEP_W) ? PHASE_BITS : STEP_W;
    localparam int VP_W   = MAG_W + VOLUME_W;
    localparam int DP_W   = PROD_W + RECIP_W;
    localparam logic [FIELD_FRAME_W-1:0] FMASK =
        FIELD_FRAME_W'((64'd1 << FW) - 64'd1);

    // quarter-wave table, entries 0 .. QSIZE inclusive
    logic [MAG_W-1:0] qtab [QSIZE+1];

    for (genvar g = 0; g <= QSIZE; g++)
    begin : g_qtab
        assign qtab[g] = quarter_sine(32'(g), 32'(QBITS));
    end

    logic [PHASE_BITS-1:0]     phase_acc_reg;
    logic [PHASE_BITS-1:0]     phase_acc_next;
    logic [SW-1:0]             step_wide;
    logic [SINE_ADDR_BITS-1:0] phase_idx;
    logic [1:0]                quad;
    logic [RA_W-1:0]           rel;
    logic [RA_W-1:0]           rom_addr_next;

    logic [RA_W-1:0]           rom_addr_reg;
    logic                      neg_reg;
    logic                      smp_on_reg;
    logic [FIELD_FRAME_W-1:0]  free_reg;
    logic [FIELD_FRAME_W-1:0]  queued_reg;
    logic [MAG_W-1:0]          rom_reg;
    logic [MAG_W-1:0]          vmag_reg;
    logic [PROD_W-1:0]         lprod_reg;
    logic [PROD_W-1:0]         rprod_reg;

    logic [FIELD_FRAME_W-1:0]  fill_reg;
    logic signed [SAMPLE_W-1:0] left_reg;
    logic signed [SAMPLE_W-1:0] right_reg;

    always_comb
    begin
        step_wide     = SW'(phase_step);
        phase_idx     = phase_acc_reg[PHASE_BITS-1 -: SINE_ADDR_BITS];
        quad          = phase_idx[SINE_ADDR_BITS-1 -: 2];
        rel           = {1'b0, phase_idx[QBITS-1:0]};
        // mirror the index on odd quadrants
        rom_addr_next = quad[0] ? (RA_W'(QSIZE) - rel) : rel;
        if (cmd.accept && kind && enable)
        begin
            phase_acc_next = phase_acc_reg + step_wide[PHASE_BITS-1:0];
        end
        else
        begin
            phase_acc_next = phase_acc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_acc_reg <= '0;
        end
        else
        begin
            phase_acc_reg <= phase_acc_next;
        end
    end

    // fill planner
    logic [FIELD_FRAME_W-1:0] tgt;
    logic [FIELD_FRAME_W-1:0] lim;
    logic [FIELD_FRAME_W-1:0] need_lat;
    logic [FIELD_FRAME_W-1:0] need;
    logic [FIELD_FRAME_W-1:0] plan_fill;

    always_comb
    begin
        tgt      = target_frames & FMASK;
        lim      = max_frames & FMASK;
        need_lat = (tgt > queued_reg) ? (tgt - queued_reg) : '0;
        if (need_lat > free_reg)
        begin
            need_lat = free_reg;
        end
        need = latency_mode ? need_lat : free_reg;
        if (need > lim)
        begin
            need = lim;
        end
        plan_fill = enable ? need : '0;
    end

    // volume and pan
    logic [VP_W-1:0]              vol_prod;
    logic signed [PAN_W-1:0]      pan_sat;
    logic signed [PAN_W:0]        gl_s;
    logic signed [PAN_W:0]        gr_s;
    logic [GAIN_W-1:0]            gain_l;
    logic [GAIN_W-1:0]            gain_r;
    logic [DP_W-1:0]              lq_prod;
    logic [DP_W-1:0]              rq_prod;
    logic [SAMPLE_W-1:0]          lq;
    logic [SAMPLE_W-1:0]          rq;
    logic signed [SAMPLE_W-1:0]   l_val;
    logic signed [SAMPLE_W-1:0]   r_val;

    always_comb
    begin
        vol_prod = VP_W'(rom_reg) * VP_W'(volume);
        priority if (pan > PAN_SPAN)
        begin
            pan_sat = PAN_SPAN;
        end
        else if (pan < PAN_SPAN_N)
        begin
            pan_sat = PAN_SPAN_N;
        end
        else
        begin
            pan_sat = pan;
        end
        gl_s    = {PAN_SPAN[PAN_W-1], PAN_SPAN} - {pan_sat[PAN_W-1], pan_sat};
        gr_s    = {PAN_SPAN[PAN_W-1], PAN_SPAN} + {pan_sat[PAN_W-1], pan_sat};
        gain_l  = gl_s[GAIN_W-1:0];
        gain_r  = gr_s[GAIN_W-1:0];
        // divide by 200 through the reciprocal
        lq_prod = DP_W'(lprod_reg) * DP_W'(DIV_RECIP);
        rq_prod = DP_W'(rprod_reg) * DP_W'(DIV_RECIP);
        lq      = lq_prod[DIV_SHIFT +: SAMPLE_W];
        rq      = rq_prod[DIV_SHIFT +: SAMPLE_W];
        if (!smp_on_reg)
        begin
            l_val = '0;
            r_val = '0;
        end
        else if (neg_reg)
        begin
            l_val = -$signed(lq);
            r_val = -$signed(rq);
        end
        else
        begin
            l_val = $signed(lq);
            r_val = $signed(rq);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            free_reg     <= free_frames & FMASK;
            queued_reg   <= queued_frames & FMASK;
            smp_on_reg   <= enable;
            neg_reg      <= quad[1];
            rom_addr_reg <= rom_addr_next;
        end
        if (cmd.rom_load)
        begin
            rom_reg <= qtab[rom_addr_reg];
        end
        if (cmd.vol_load)
        begin
            vmag_reg <= vol_prod[VOLUME_W +: MAG_W];
        end
        if (cmd.gain_load)
        begin
            lprod_reg <= PROD_W'(vmag_reg) * PROD_W'(gain_l);
            rprod_reg <= PROD_W'(vmag_reg) * PROD_W'(gain_r);
        end
        if (cmd.out_plan)
        begin
            fill_reg  <= plan_fill;
            left_reg  <= '0;
            right_reg <= '0;
        end
        else if (cmd.out_sample)
        begin
            fill_reg  <= '0;
            left_reg  <= l_val;
            right_reg <= r_val;
        end
    end

    assign fill_count   = fill_reg;
    assign left_sample  = left_reg;
    assign right_sample = right_reg;

endmodule

// ===== hdl/sine_tone_generator_with_pan.sv =====
// Top level: configuration registers, controller and datapath of the panned sine tone generator.
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------------
//  in      | in_valid / in_stall  | kind, free_frames, queued_frames
//  out     | out_valid / out_stall| fill_count, left_sample, right_sample
//  cfg     | cfg_write            | cfg_index, cfg_data
//
//  A plan request passes the plan stage into the result register; a sample request passes
//  the table lookup, volume multiply, pan multiply and reciprocal divide stages in order.
//  One request is in the stage registers at a time and in_stall stays high until the
//  controller is idle again, so a new request is taken only once the last one is through.
//  The last stage waits while a result is held under out_stall; a held result does not
//  block the next acceptance. Reset clears the phase accumulator and loads the defaults.
module sine_tone_generator_with_pan
    import stgwp_pkg::*;
#(
    parameter int PHASE_BITS     = PHASE_BITS_DEF,
    parameter int SINE_ADDR_BITS = SINE_ADDR_BITS_DEF,
    parameter int FRAME_BITS     = FRAME_BITS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       kind,
    input  logic [FIELD_FRAME_W-1:0]   free_frames,
    input  logic [FIELD_FRAME_W-1:0]   queued_frames,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [FIELD_FRAME_W-1:0]   fill_count,
    output logic signed [SAMPLE_W-1:0] left_sample,
    output logic signed [SAMPLE_W-1:0] right_sample,
    input  logic                       cfg_write,
    input  logic [CFG_INDEX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data
);

    logic                      enable_reg;
    logic                      latency_reg;
    logic [FIELD_FRAME_W-1:0]  target_reg;
    logic [FIELD_FRAME_W-1:0]  max_reg;
    logic [VOLUME_W-1:0]       volume_reg;
    logic signed [PAN_W-1:0]   pan_reg;
    logic [STEP_W-1:0]         step_reg;
    dp_cmd_t                   cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg  <= ENABLE_RST;
            latency_reg <= LATENCY_RST;
            target_reg  <= TARGET_RST;
            max_reg     <= MAX_RST;
            volume_reg  <= VOLUME_RST;
            pan_reg     <= PAN_RST;
            step_reg    <= STEP_RST;
        end
        else if (cfg_write)
        begin
            // drop writes to indexes beyond the register list
            unique case (cfg_index)
                REG_ENABLE:       enable_reg  <= cfg_data[0];
                REG_LATENCY_MODE: latency_reg <= cfg_data[0];
                REG_TARGET:       target_reg  <= cfg_data[FIELD_FRAME_W-1:0];
                REG_MAX:          max_reg     <= cfg_data[FIELD_FRAME_W-1:0];
                REG_VOLUME:       volume_reg  <= cfg_data[VOLUME_W-1:0];
                REG_PAN:          pan_reg     <= $signed(cfg_data[PAN_W-1:0]);
                REG_PHASE_STEP:   step_reg    <= cfg_data[STEP_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    stgwp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .kind      (kind),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    stgwp_datapath #(
        .PHASE_BITS     (PHASE_BITS),
        .SINE_ADDR_BITS (SINE_ADDR_BITS),
        .FRAME_BITS     (FRAME_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .kind          (kind),
        .free_frames   (free_frames),
        .queued_frames (queued_frames),
        .enable        (enable_reg),
        .latency_mode  (latency_reg),
        .target_frames (target_reg),
        .max_frames    (max_reg),
        .volume        (volume_reg),
        .pan           (pan_reg),
        .phase_step    (step_reg),
        .fill_count    (fill_count),
        .left_sample   (left_sample),
        .right_sample  (right_sample)
    );

endmodule

// ===== tb/tone_pan_checker.sv =====
`timescale 1ns / 1ps
// Request and result monitor for the panned tone generator: predicts every result and compares.
module tone_pan_checker
    import stgwp_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_stall,
    input  logic                       kind,
    input  logic [FIELD_FRAME_W-1:0]   free_frames,
    input  logic [FIELD_FRAME_W-1:0]   queued_frames,
    input  logic                       out_valid,
    input  logic                       out_stall,
    input  logic [FIELD_FRAME_W-1:0]   fill_count,
    input  logic signed [SAMPLE_W-1:0] left_sample,
    input  logic signed [SAMPLE_W-1:0] right_sample,
    input  logic                       cfg_write,
    input  logic [CFG_INDEX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    output int                         mismatches,
    output int                         outstanding
);

    localparam int              TAB_BITS         = 10;
    localparam int              QUARTER          = 1 << (TAB_BITS - 2);
    localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
    localparam int              AMP_SCALE        = 32768;
    localparam int              PAN_LIMIT        = 100;
    localparam int              PAN_DIVISOR      = 200;
    localparam int              REPORT_LIMIT     = 10;

    typedef struct packed {
        logic [FIELD_FRAME_W-1:0]   fill;
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
    } tone_frame_t;

    logic signed [SAMPLE_W-1:0] sine_tab [0:(1 << TAB_BITS) - 1];
    tone_frame_t                frames_due [$];

    logic                       en_r;
    logic                       lat_r;
    logic [FIELD_FRAME_W-1:0]   target_r;
    logic [FIELD_FRAME_W-1:0]   max_r;
    logic [VOLUME_W-1:0]        vol_r;
    logic signed [PAN_W-1:0]    pan_r;
    logic [STEP_W-1:0]          step_r;
    logic [31:0]                phase_r;
    int                         bad_count;
    int                         frame_no;

    // Taylor series of sin(x) to the x^13 term in Q2.30, rounded to Q15
    function automatic int quarter_amp(input int unsigned r);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned odd_sum;
        longint unsigned even_sum;
        longint unsigned acc;
        longint unsigned den;
        x        = (QUARTER_TURN_Q30 * r) >> (TAB_BITS - 2);
        x2       = (x * x) >> 30;
        term     = x;
        odd_sum  = x;
        even_sum = 64'd0;
        for (int n = 0; n < 6; n++)
        begin
            den  = 64'((2 * n + 2) * (2 * n + 3));
            term = ((term * x2) >> 30) / den;
            if (n % 2 == 1)
                odd_sum = odd_sum + term;
            else
                even_sum = even_sum + term;
        end
        acc = (odd_sum >= even_sum) ? odd_sum - even_sum : 64'd0;
        acc = (acc + 64'd16384) >> 15;
        if (acc > 64'd32767)
            acc = 64'd32767;
        return int'(acc);
    endfunction

    initial
    begin
        int          mag;
        int unsigned quad;
        int unsigned r;
        for (int idx = 0; idx < (1 << TAB_BITS); idx++)
        begin
            quad = (idx >> (TAB_BITS - 2)) & 3;
            r    = idx & (QUARTER - 1);
            // odd quadrants run the quarter wave backwards, the upper half of the table is negated
            mag  = quad[0] ? quarter_amp(QUARTER - r) : quarter_amp(r);
            sine_tab[idx] = quad[1] ? SAMPLE_W'(-mag) : SAMPLE_W'(mag);
        end
    end

    function automatic tone_frame_t predict_frame(input logic k,
                                                  input logic [FIELD_FRAME_W-1:0] f,
                                                  input logic [FIELD_FRAME_W-1:0] q);
        tone_frame_t res;
        int          need;
        int          free_i;
        int          queued_i;
        int          tgt_i;
        int          lim_i;
        int          s;
        int          vol_i;
        int          v;
        int          p;
        res      = '0;
        free_i   = int'(f);
        queued_i = int'(q);
        tgt_i    = int'(target_r);
        lim_i    = int'(max_r);
        vol_i    = int'(vol_r);
        if (!en_r)
            return res;
        if (!k)
        begin
            if (lat_r)
            begin
                need = tgt_i - queued_i;
                if (need < 0)
                    need = 0;
                if (need > free_i)
                    need = free_i;
            end
            else
                need = free_i;
            if (need > lim_i)
                need = lim_i;
            res.fill = FIELD_FRAME_W'(need);
        end
        else
        begin
            s = int'(sine_tab[phase_r[31 -: TAB_BITS]]);
            v = (s * vol_i) / AMP_SCALE;
            p = int'(pan_r);
            if (p > PAN_LIMIT)
                p = PAN_LIMIT;
            if (p < -PAN_LIMIT)
                p = -PAN_LIMIT;
            res.left  = SAMPLE_W'((v * (PAN_LIMIT - p)) / PAN_DIVISOR);
            res.right = SAMPLE_W'((v * (PAN_LIMIT + p)) / PAN_DIVISOR);
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        tone_frame_t want;
        tone_frame_t got;
        if (!rst_n)
        begin
            en_r     = 1'b0;
            lat_r    = 1'b1;
            target_r = 16'd3200;
            max_r    = 16'd3200;
            vol_r    = 15'd6000;
            pan_r    = 8'sd0;
            step_r   = 32'd22967740;
            phase_r  = '0;
            bad_count = 0;
            frame_no  = 0;
            frames_due.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_ENABLE:       en_r     = cfg_data[0];
                    REG_LATENCY_MODE: lat_r    = cfg_data[0];
                    REG_TARGET:       target_r = cfg_data[15:0];
                    REG_MAX:          max_r    = cfg_data[15:0];
                    REG_VOLUME:       vol_r    = cfg_data[14:0];
                    REG_PAN:          pan_r    = cfg_data[7:0];
                    REG_PHASE_STEP:   step_r   = cfg_data;
                    default:          ;
                endcase
            end
            // retire a result before queuing a new request
            if (out_valid && !out_stall)
            begin
                got.fill  = fill_count;
                got.left  = left_sample;
                got.right = right_sample;
                if (frames_due.size() == 0)
                begin
                    bad_count++;
                    if (bad_count <= REPORT_LIMIT)
                        $display("result %0d arrived with nothing due: %s %0d %0d %0d",
                                 frame_no, "fill/left/right", got.fill, got.left,
                                 got.right);
                end
                else
                begin
                    want = frames_due.pop_front();
                    if (want != got)
                    begin
                        bad_count++;
                        if (bad_count <= REPORT_LIMIT)
                            $display({"result %0d: fill %0d want %0d, ",
                                      "left %0d want %0d, right %0d want %0d"},
                                     frame_no, got.fill, want.fill, got.left, want.left,
                                     got.right, want.right);
                    end
                end
                frame_no++;
            end
            if (in_valid && !in_stall)
            begin
                frames_due.push_back(predict_frame(kind, free_frames, queued_frames));
                // the accumulator only advances on an enabled sample request
                if (kind && en_r)
                    phase_r = phase_r + step_r;
            end
            mismatches  <= bad_count;
            outstanding <= frames_due.size();
        end
    end

endmodule

// ===== tb/tb_sine_tone_generator_with_pan.sv =====
`timescale 1ns / 1ps
// Stimulus, flow control and verdict for the panned sine tone generator.
module tb_sine_tone_generator_with_pan;
    import stgwp_pkg::*;

    localparam int                   WATCHDOG_CYCLES = 2000;
    localparam int                   HOLD_CYCLES     = 300;
    localparam int                   RANDOM_PHASES   = 15;
    localparam int                   REQS_PER_PHASE  = 104;
    localparam int                   SQUEEZE_PHASE   = 2;
    localparam logic                 KIND_PLAN       = 1'b0;
    localparam logic                 KIND_SAMPLE     = 1'b1;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE     = 3'd7;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic                       kind;
    logic [FIELD_FRAME_W-1:0]   free_frames;
    logic [FIELD_FRAME_W-1:0]   queued_frames;
    logic                       out_valid;
    logic                       out_stall;
    logic [FIELD_FRAME_W-1:0]   fill_count;
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
    logic                       cfg_write;
    logic [CFG_INDEX_W-1:0]     cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_data;
    int                         mismatches;
    int                         outstanding;

    bit                         gaps_on;
    bit                         stalls_on;
    bit                         squeeze;
    int                         tgt_cur;
    int                         quiet_cycles;

    sine_tone_generator_with_pan dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .kind          (kind),
        .free_frames   (free_frames),
        .queued_frames (queued_frames),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .fill_count    (fill_count),
        .left_sample   (left_sample),
        .right_sample  (right_sample),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    tone_pan_checker tone_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .kind          (kind),
        .free_frames   (free_frames),
        .queued_frames (queued_frames),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .fill_count    (fill_count),
        .left_sample   (left_sample),
        .right_sample  (right_sample),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    initial
        clk = 1'b0;

    always #5 clk = ~clk;

    function automatic int pick_gap();
        int r;
        if (!gaps_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [31:0] pick_field(input int width);
        logic [31:0] keep;
        int          r;
        keep = (width >= 32) ? 32'hFFFF_FFFF : ((32'd1 << width) - 1);
        r    = $urandom_range(0, 7);
        case (r)
            0:       return 32'd0;
            1:       return keep;
            2:       return 32'd1;
            3, 4:    return $urandom_range(0, 4000) & keep;
            default: return $urandom & keep;
        endcase
    endfunction

    // upper data bits carry junk so the register width masking gets exercised
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] value,
                             input int width);
        logic [31:0] keep;
        keep = (width >= 32) ? 32'hFFFF_FFFF : ((32'd1 << width) - 1);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = ($urandom & ~keep) | (value & keep);
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    task automatic send_req(input logic k, input logic [FIELD_FRAME_W-1:0] f,
                            input logic [FIELD_FRAME_W-1:0] q);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap)
            begin
                kind          = 1'($urandom);
                free_frames   = FIELD_FRAME_W'($urandom);
                queued_frames = FIELD_FRAME_W'($urandom);
                @(negedge clk);
            end
        end
        in_valid      = 1'b1;
        kind          = k;
        free_frames   = f;
        queued_frames = q;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // drop the request line and wait until every result is back
    task automatic settle();
        @(negedge clk);
        in_valid = 1'b0;
        while (outstanding != 0)
            @(posedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic random_req();
        logic [FIELD_FRAME_W-1:0] f;
        logic [FIELD_FRAME_W-1:0] q;
        int                       pick;
        int                       near;
        if ($urandom_range(0, 1) == 1)
            send_req(KIND_SAMPLE, FIELD_FRAME_W'($urandom), FIELD_FRAME_W'($urandom));
        else
        begin
            pick = $urandom_range(0, 9);
            if (pick < 2)
                f = '0;
            else if (pick < 4)
                f = '1;
            else if (pick < 7)
                f = FIELD_FRAME_W'($urandom_range(0, 4000));
            else
                f = FIELD_FRAME_W'($urandom);
            pick = $urandom_range(0, 9);
            near = tgt_cur + $urandom_range(0, 6000) - 3000;
            if (near < 0)
                near = 0;
            if (near > 65535)
                near = 65535;
            if (pick < 1)
                q = '0;
            else if (pick < 2)
                q = '1;
            else if (pick < 7)
                q = FIELD_FRAME_W'(near);
            else
                q = FIELD_FRAME_W'($urandom);
            send_req(KIND_PLAN, f, q);
        end
    endtask

    task automatic random_setting();
        logic [31:0] pan_val;
        int          r;
        write_reg(REG_ENABLE, 32'($urandom_range(0, 6) != 0), 1);
        write_reg(REG_LATENCY_MODE, $urandom_range(0, 1), 1);
        tgt_cur = pick_field(FIELD_FRAME_W);
        write_reg(REG_TARGET, tgt_cur, FIELD_FRAME_W);
        write_reg(REG_MAX, pick_field(FIELD_FRAME_W), FIELD_FRAME_W);
        write_reg(REG_VOLUME, pick_field(VOLUME_W), VOLUME_W);
        r = $urandom_range(0, 7);
        case (r)
            0:       pan_val = 32'h80;
            1:       pan_val = 32'h7F;
            2:       pan_val = 32'h9C;
            3:       pan_val = 32'h64;
            4:       pan_val = 32'h00;
            default: pan_val = $urandom_range(0, 255);
        endcase
        write_reg(REG_PAN, pan_val, PAN_W);
        write_reg(REG_PHASE_STEP, pick_field(STEP_W), STEP_W);
        if ($urandom_range(0, 3) == 0)
            write_reg(REG_SPARE, $urandom, 32);
    endtask

    // receiver: random back-pressure, plus one long hold when asked
    initial
    begin
        int r;
        int hold;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (squeeze)
            begin
                out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                out_stall = 1'b0;
                squeeze   = 1'b0;
            end
            else if (!stalls_on)
                out_stall = 1'b0;
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 65)
                    out_stall = 1'b0;
                else
                begin
                    out_stall = 1'b1;
                    hold = (r < 95) ? $urandom_range(1, 3) : $urandom_range(20, 60);
                    repeat (hold - 1) @(negedge clk);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_CYCLES)
        begin
            $display("sine_tone_generator_with_pan verification failed");
            $finish;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        kind          = KIND_PLAN;
        free_frames   = '0;
        queued_frames = '0;
        cfg_write     = 1'b0;
        cfg_index     = REG_ENABLE;
        cfg_data      = '0;
        gaps_on       = 1'b1;
        stalls_on     = 1'b1;
        squeeze       = 1'b0;
        tgt_cur       = 3200;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // disabled after reset: plans give zero, samples give silence
        send_req(KIND_PLAN, 16'd100, 16'd0);
        send_req(KIND_SAMPLE, 16'd0, 16'd0);
        settle();
        write_reg(REG_ENABLE, 32'd1, 1);

        // latency mode at the reset target and chunk
        send_req(KIND_PLAN, 16'hFFFF, 16'd0);
        send_req(KIND_PLAN, 16'hFFFF, 16'hFFFF);
        send_req(KIND_PLAN, 16'd1, 16'd3199);
        send_req(KIND_PLAN, 16'd0, 16'd0);
        send_req(KIND_SAMPLE, 16'hFFFF, 16'hFFFF);
        send_req(KIND_SAMPLE, 16'd0, 16'd0);
        settle();

        // fill-all mode, zero chunk then widest chunk
        write_reg(REG_LATENCY_MODE, 32'd0, 1);
        write_reg(REG_MAX, 32'd0, FIELD_FRAME_W);
        send_req(KIND_PLAN, 16'hFFFF, 16'd0);
        settle();
        write_reg(REG_MAX, 32'h0000_FFFF, FIELD_FRAME_W);
        send_req(KIND_PLAN, 16'hFFFF, 16'd7);
        settle();

        // full volume, hard right beyond range, quarter-turn steps through each quadrant
        write_reg(REG_VOLUME, 32'h0000_7FFF, VOLUME_W);
        write_reg(REG_PAN, 32'h7F, PAN_W);
        write_reg(REG_PHASE_STEP, 32'h4000_0000, STEP_W);
        repeat (5) send_req(KIND_SAMPLE, FIELD_FRAME_W'($urandom), FIELD_FRAME_W'($urandom));
        settle();
        write_reg(REG_PAN, 32'h80, PAN_W);
        repeat (2) send_req(KIND_SAMPLE, FIELD_FRAME_W'($urandom), FIELD_FRAME_W'($urandom));
        settle();

        // widest target in latency mode
        write_reg(REG_LATENCY_MODE, 32'd1, 1);
        write_reg(REG_TARGET, 32'h0000_FFFF, FIELD_FRAME_W);
        tgt_cur = 65535;
        send_req(KIND_PLAN, 16'hFFFF, 16'd0);
        send_req(KIND_PLAN, 16'd40000, 16'd100);
        settle();

        // phase holds while disabled; unused register index is ignored
        write_reg(REG_ENABLE, 32'd0, 1);
        write_reg(REG_SPARE, 32'hFFFF_FFFF, 32);
        send_req(KIND_SAMPLE, 16'd0, 16'd0);
        settle();
        write_reg(REG_ENABLE, 32'd1, 1);
        send_req(KIND_SAMPLE, 16'd0, 16'd0);
        settle();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            random_setting();
            gaps_on   = ($urandom_range(0, 3) != 0);
            stalls_on = ($urandom_range(0, 3) != 0);
            if (ph == SQUEEZE_PHASE)
            begin
                gaps_on = 1'b0;
                squeeze = 1'b1;
            end
            repeat (REQS_PER_PHASE) random_req();
            settle();
        end

        if (mismatches == 0 && outstanding == 0)
            $display("sine_tone_generator_with_pan verification clean");
        else
            $display("sine_tone_generator_with_pan verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/stgwp_pkg.sv
hdl/stgwp_ctrl.sv
hdl/stgwp_datapath.sv
hdl/sine_tone_generator_with_pan.sv
tb/tone_pan_checker.sv
tb/tb_sine_tone_generator_with_pan.sv
